>>> hw/rtl/slp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slp_pkg;

  localparam int SIZE_BITS_DEF = 24;

  localparam logic [1:0] PH_CMD  = 2'd0;
  localparam logic [1:0] PH_SIZE = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_HELP    = 3'd1;
  localparam logic [2:0] EV_UNKNOWN = 3'd2;
  localparam logic [2:0] EV_PROG    = 3'd3;
  localparam logic [2:0] EV_SIZE_OK = 3'd4;
  localparam logic [2:0] EV_DONE    = 3'd5;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [7:0] PRE_FILL  = 8'hFF;
  localparam logic [7:0] PRE_SYNC0 = 8'hBD;
  localparam logic [7:0] PRE_SYNC1 = 8'hB3;

  localparam int PRE_LEN   = 18;
  localparam int PRE_IDX_W = $clog2(PRE_LEN);

  typedef logic [PRE_IDX_W-1:0] pre_idx_t;

  function automatic logic [7:0] pre_byte(input pre_idx_t idx);
    logic [7:0] b;
    if (idx == pre_idx_t'(PRE_LEN - 2)) begin
      b = PRE_SYNC0;
    end else if (idx == pre_idx_t'(PRE_LEN - 1)) begin
      b = PRE_SYNC1;
    end else begin
      b = PRE_FILL;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/serial_bitstream_loader_parser.sv
// Inputs pass the input, then the output register. Throughput if not stalled:
// one input transaction per cycle; a carriage return ending size entry
// yields 18 preamble results, one per cycle, during which input holds. Sizes
// are accumulated one digit per transaction in one multiply-by-ten add.
// Reset: synchronous, active low; returns to the command phase with size,
// count and digit flags cleared and both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module serial_bitstream_loader_parser
  import slp_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_kind,
  output logic [7:0]      out_spi_byte,
  output logic [2:0]      out_event_res,
  output logic            out_last
);

  localparam int ACC_W = SIZE_BITS + 4;

  logic                 in_valid_r, in_valid_nxt;
  logic [7:0]           in_byte_r;

  logic [1:0]           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic [SIZE_BITS-1:0] count_r, count_nxt;
  logic                 dstart_r, dstart_nxt;
  logic                 dend_r, dend_nxt;

  logic                 pre_active_r, pre_active_nxt;
  pre_idx_t             pre_idx_r, pre_idx_nxt;
  logic                 pre_zero_r, pre_zero_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic [2:0]           out_ev_r, out_ev_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 out_free;
  logic                 s1_fire;
  logic                 in_take;
  logic                 is_digit;
  logic [ACC_W-1:0]     acc;
  logic [SIZE_BITS-1:0] size_sat;
  logic [SIZE_BITS-1:0] count_inc;
  logic                 pre_end;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = in_valid_r && out_free && !pre_active_r;
  assign in_stall = in_valid_r && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  assign is_digit = (in_byte_r >= CH_0) && (in_byte_r <= CH_9);
  assign acc = ({4'b0, size_r} << 3) + ({4'b0, size_r} << 1)
             + {{SIZE_BITS{1'b0}}, in_byte_r[3:0]};
  assign size_sat = (|acc[ACC_W-1:SIZE_BITS]) ? {SIZE_BITS{1'b1}} : acc[SIZE_BITS-1:0];
  assign count_inc = count_r + {{(SIZE_BITS-1){1'b0}}, 1'b1};
  assign pre_end = (pre_idx_r == pre_idx_t'(PRE_LEN - 1));

  always_comb begin
    in_valid_nxt   = in_valid_r;
    phase_nxt      = phase_r;
    size_nxt       = size_r;
    count_nxt      = count_r;
    dstart_nxt     = dstart_r;
    dend_nxt       = dend_r;
    pre_active_nxt = pre_active_r;
    pre_idx_nxt    = pre_idx_r;
    pre_zero_nxt   = pre_zero_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_byte_nxt   = out_byte_r;
    out_ev_nxt     = out_ev_r;
    out_last_nxt   = out_last_r;

    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      in_valid_nxt = 1'b0;
    end

    if (out_free) begin
      out_valid_nxt = 1'b0;
    end

    if (pre_active_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = 1'b1;
      out_byte_nxt  = pre_byte(pre_idx_r);
      out_ev_nxt    = (pre_end && pre_zero_r) ? EV_DONE : EV_NONE;
      out_last_nxt  = pre_end;
      if (pre_end) begin
        pre_active_nxt = 1'b0;
      end else begin
        pre_idx_nxt = pre_idx_r + pre_idx_t'(1);
      end
    end else if (s1_fire) begin
      case (phase_r)
        PH_SIZE: begin
          if (in_byte_r == CH_CR) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = 1'b1;
            out_byte_nxt   = pre_byte(pre_idx_t'(0));
            out_ev_nxt     = EV_SIZE_OK;
            out_last_nxt   = 1'b0;
            pre_active_nxt = 1'b1;
            pre_idx_nxt    = pre_idx_t'(1);
            pre_zero_nxt   = (size_r == '0);
            count_nxt      = '0;
            dstart_nxt     = 1'b0;
            dend_nxt       = 1'b0;
            phase_nxt      = (size_r == '0) ? PH_CMD : PH_DATA;
          end else if (!dend_r) begin
            if (is_digit) begin
              size_nxt   = size_sat;
              dstart_nxt = 1'b1;
            end else if (!(in_byte_r == CH_SPACE && !dstart_r)) begin
              dend_nxt = 1'b1;
            end
          end
        end
        PH_DATA: begin
          count_nxt     = count_inc;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_byte_nxt  = in_byte_r;
          out_last_nxt  = 1'b1;
          if (count_inc >= size_r) begin
            out_ev_nxt = EV_DONE;
            phase_nxt  = PH_CMD;
          end else begin
            out_ev_nxt = EV_NONE;
          end
        end
        default: begin
          phase_nxt     = PH_CMD;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_byte_nxt  = 8'h00;
          out_last_nxt  = 1'b1;
          if (in_byte_r == CH_CR) begin
            out_ev_nxt = EV_HELP;
          end else if (in_byte_r == CH_P) begin
            out_ev_nxt = EV_PROG;
            size_nxt   = '0;
            count_nxt  = '0;
            dstart_nxt = 1'b0;
            dend_nxt   = 1'b0;
            phase_nxt  = PH_SIZE;
          end else begin
            out_ev_nxt = EV_UNKNOWN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      phase_r      <= PH_CMD;
      size_r       <= '0;
      count_r      <= '0;
      dstart_r     <= 1'b0;
      dend_r       <= 1'b0;
      pre_active_r <= 1'b0;
      pre_idx_r    <= '0;
      pre_zero_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      in_valid_r   <= in_valid_nxt;
      phase_r      <= phase_nxt;
      size_r       <= size_nxt;
      count_r      <= count_nxt;
      dstart_r     <= dstart_nxt;
      dend_r       <= dend_nxt;
      pre_active_r <= pre_active_nxt;
      pre_idx_r    <= pre_idx_nxt;
      pre_zero_r   <= pre_zero_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_spi_byte  = out_byte_r;
  assign out_event_res = out_ev_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

>>> hw/rtl/slp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module slp_checker
  import slp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_kind,
  input wire logic [7:0] out_spi_byte,
  input wire logic [2:0] out_event_res,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind)
      && $stable(out_spi_byte) && $stable(out_event_res) && $stable(out_last))
    else $error("result changed while stalled");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_spi_byte == 8'h00)
    else $error("status transaction carries a data byte");

  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_HELP || out_event_res == EV_UNKNOWN
      || out_event_res == EV_PROG) |-> !out_kind && out_last)
    else $error("command event not a single status transaction");

  a_pre_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_SIZE_OK |->
      out_kind && out_spi_byte == PRE_FILL && !out_last)
    else $error("preamble start malformed");

  a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res <= EV_DONE)
    else $error("event code out of range");

endmodule

bind serial_bitstream_loader_parser slp_checker u_slp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_spi_byte  (out_spi_byte),
  .out_event_res (out_event_res),
  .out_last      (out_last)
);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import slp_pkg::*;

  localparam int                 SZ_BITS      = SIZE_BITS_DEF;
  localparam logic [SZ_BITS-1:0] SIZE_MAX     = '1;
  localparam int                 RUN_LIMIT    = 1000000;
  localparam int                 RANDOM_ITEMS = 250;

  typedef struct packed {
    logic       kind;
    logic [7:0] spi_byte;
    logic [2:0] ev;
    logic       last;
  } ldr_result_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_rx_byte   = 8'h00;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_spi_byte;
  logic [2:0] out_event_res;
  logic       out_last;

  // loader state as the block should hold it
  logic [1:0]         ld_phase      = PH_CMD;
  logic [SZ_BITS-1:0] req_size      = '0;
  logic [SZ_BITS-1:0] fwd_count     = '0;
  logic               digit_seen    = 1'b0;
  logic               number_closed = 1'b0;

  ldr_result_t expected_results[$];
  int          errors     = 0;
  int          cycles     = 0;
  int          items_sent = 0;
  int          stall_left = 0;
  bit          quiet      = 1'b0;

  serial_bitstream_loader_parser dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_spi_byte (out_spi_byte),
    .out_event_res(out_event_res),
    .out_last     (out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_result(input logic k, input logic [7:0] b,
                                      input logic [2:0] e, input logic l);
    ldr_result_t r;
    r.kind     = k;
    r.spi_byte = b;
    r.ev       = e;
    r.last     = l;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_loader(input logic [7:0] b);
    logic [63:0] acc;
    logic [7:0]  pb;
    logic [2:0]  ev;
    bit          zero;
    case (ld_phase)
      PH_SIZE: begin
        if (b == CH_CR) begin
          zero = (req_size == '0);
          for (int i = 0; i < PRE_LEN; i++) begin
            pb = (i < PRE_LEN - 2) ? PRE_FILL : (i == PRE_LEN - 2) ? PRE_SYNC0 : PRE_SYNC1;
            ev = (i == 0) ? EV_SIZE_OK : EV_NONE;
            if (i == PRE_LEN - 1 && zero) ev = EV_DONE;
            push_result(1'b1, pb, ev, i == PRE_LEN - 1);
          end
          fwd_count     = '0;
          digit_seen    = 1'b0;
          number_closed = 1'b0;
          ld_phase      = zero ? PH_CMD : PH_DATA;
        end else if (!number_closed) begin
          if (b >= CH_0 && b <= CH_9) begin
            acc        = 64'(req_size) * 64'd10 + 64'(b - CH_0);
            req_size   = (acc > 64'(SIZE_MAX)) ? SIZE_MAX : acc[SZ_BITS-1:0];
            digit_seen = 1'b1;
          end else if (!(b == CH_SPACE && !digit_seen)) begin
            number_closed = 1'b1;
          end
        end
      end
      PH_DATA: begin
        fwd_count = fwd_count + SZ_BITS'(1);
        if (fwd_count >= req_size) begin
          ld_phase = PH_CMD;
          push_result(1'b1, b, EV_DONE, 1'b1);
        end else begin
          push_result(1'b1, b, EV_NONE, 1'b1);
        end
      end
      default: begin
        ld_phase = PH_CMD;
        if (b == CH_CR) begin
          push_result(1'b0, 8'h00, EV_HELP, 1'b1);
        end else if (b == CH_P) begin
          req_size      = '0;
          fwd_count     = '0;
          digit_seen    = 1'b0;
          number_closed = 1'b0;
          ld_phase      = PH_SIZE;
          push_result(1'b0, 8'h00, EV_PROG, 1'b1);
        end else begin
          push_result(1'b0, 8'h00, EV_UNKNOWN, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    if (errors <= 50) begin
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_loader(b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return CH_CR;
    if (r == 2) return CH_P;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] closing_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((b >= CH_0 && b <= CH_9) || b == CH_CR || b == CH_SPACE);
    return b;
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(100, 300);
  endfunction

  task automatic test_commands();
    send_byte(CH_CR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("p");
    wait_drained();
  endtask

  task automatic test_zero_size();
    send_byte(CH_P);
    send_byte(CH_CR);
    send_text("P-7");
    send_byte(CH_CR);
    wait_drained();
  endtask

  task automatic test_size_parsing();
    // leading space skipped, leading zero kept, space closes the number
    send_text("P 03 x9");
    send_byte(CH_CR);
    send_byte(CH_CR);
    send_byte(CH_P);
    send_byte(8'hFF);
    send_text("P1");
    send_byte(CH_CR);
    send_byte(8'h00);
    wait_drained();
  endtask

  task automatic test_random();
    int         sel;
    int         sz;
    int         n;
    int         digits[$];
    logic [7:0] b;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 4) == 0);
      sel   = $urandom_range(0, 9);
      if (sel < 2) begin
        send_byte(($urandom_range(0, 3) == 0) ? CH_CR : 8'($urandom_range(0, 255)));
      end else if (sel < 3) begin
        send_byte(CH_P);
        if ($urandom_range(0, 1)) begin
          send_byte(closing_byte());
          n = $urandom_range(0, 3);
          repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
            send_byte(b);
          end
        end
        send_byte(CH_CR);
      end else begin
        sz = pick_size();
        digits.delete();
        do begin
          digits.push_front(sz % 10);
          sz = sz / 10;
        end while (sz > 0);
        send_byte(CH_P);
        repeat ($urandom_range(0, 2)) send_byte(CH_SPACE);
        repeat ($urandom_range(0, 2)) send_byte(CH_0);
        if (!(digits.size() == 1 && digits[0] == 0 && $urandom_range(0, 1))) begin
          foreach (digits[i]) send_byte(CH_0 + 8'(digits[i]));
        end
        if ($urandom_range(0, 2) == 0) begin
          send_byte($urandom_range(0, 1) ? CH_SPACE : closing_byte());
          n = $urandom_range(0, 2);
          repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
            send_byte(b);
          end
        end
        send_byte(CH_CR);
      end
      while (ld_phase == PH_DATA) send_byte(payload_byte());
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    quiet = 1'b0;
    wait_drained();
  endtask

  task automatic test_saturation();
    // would wrap to one if not clamped; the block stays in payload afterwards
    send_text("P16777217");
    send_byte(CH_CR);
    repeat (3) send_byte(payload_byte());
    wait_drained();
  endtask

  always @(posedge clk) begin : stall_gen
    int len;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      len = quiet ? 0 : pick_gap();
      if (len > 0) begin
        out_stall  <= 1'b1;
        stall_left = len - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    ldr_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", out_spi_byte, 8'h00);
      end else begin
        want = expected_results.pop_front();
        if (out_kind !== want.kind) begin
          report_mismatch("kind", 8'(out_kind), 8'(want.kind));
        end
        if (out_spi_byte !== want.spi_byte) begin
          report_mismatch("spi_byte", out_spi_byte, want.spi_byte);
        end
        if (out_event_res !== want.ev) begin
          report_mismatch("event", 8'(out_event_res), 8'(want.ev));
        end
        if (out_last !== want.last) begin
          report_mismatch("last", 8'(out_last), 8'(want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_commands();
    test_zero_size();
    test_size_parsing();
    test_random();
    test_saturation();
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
